// ===== hw/rtl/combinadic_rank_unrank_macros.svh =====
// assertion macros shared by the rtl of the combinadic rank / unrank block
// depends on a clk and an active-low rst_n in the including scope
`ifndef COMBINADIC_RANK_UNRANK_MACROS_SVH
`define COMBINADIC_RANK_UNRANK_MACROS_SVH

// implication checked at every clock edge outside reset
`define CRU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// invariant checked at every clock edge outside reset
`define CRU_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// ===== hw/rtl/cru_pkg.sv =====
// constants and shared types of the combinadic rank / unrank block
// no dependencies
package cru_pkg;

  localparam int DATA_W      = 64;   // fixed width of the value fields
  localparam int VW          = 64;   // working value width
  localparam int MAX_SUBSET  = 64;
  localparam int KW          = 7;    // width of sizes, positions and counts
  localparam int AW          = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [VW-1:0] VMAX = {VW{1'b1}};

  // register indexes
  localparam logic REG_SUBSET_SIZE  = 1'b0;
  localparam logic REG_ELEMENT_FORM = 1'b1;

  typedef struct packed {
    logic          start;
    logic [VW-1:0] n;
    logic [KW-1:0] k;
  } bin_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic          sat;
    logic [VW-1:0] val;
  } bin_rsp_t;

endpackage

// ===== hw/rtl/cru_if.sv =====
// request and result channel interfaces of the combinadic rank / unrank block
// depends on cru_pkg
interface cru_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [cru_pkg::DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cru_out_if;
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic [cru_pkg::DATA_W-1:0] result_value;
  logic [cru_pkg::KW-1:0]     position;
  logic                      overflow;
  logic                      last;

  modport source (output valid, output result_kind, output result_value, output position,
                  output overflow, output last, input ready);
  modport sink   (input valid, input result_kind, input result_value, input position,
                  input overflow, input last, output ready);
endinterface

// ===== hw/rtl/cru_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module cru_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/cru_binom.sv =====
// binomial coefficient unit: c = c * (n - k + j) / j for j = 1..k, saturating
// depends on cru_pkg; one half-width multiplier and a bit-serial divider
module cru_binom (
  input  logic              clk,
  input  logic              rst_n,
  input  cru_pkg::bin_req_t req,
  output cru_pkg::bin_rsp_t rsp
);

  localparam int VW = cru_pkg::VW;
  localparam int KW = cru_pkg::KW;
  localparam int HW = (VW + 1) / 2;
  localparam int CW = $clog2(2 * VW);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_MUL  = 3'b010,
    B_DIV  = 3'b100
  } bst_t;

  bst_t              st_r;
  logic [KW-1:0]     k_r;
  logic [KW-1:0]     j_r;
  logic [VW-1:0]     c_r;
  logic [VW-1:0]     f_r;
  logic [2*VW-1:0]   acc_r;
  logic [2*HW-1:0]   pp_r;
  logic [2:0]        ph_r;
  logic [1:0]        sh_r;
  logic [KW-1:0]     rem_r;
  logic [CW-1:0]     cnt_r;
  logic              done_r;
  logic              sat_r;
  logic [VW-1:0]     val_r;

  logic [2*HW-1:0]   c_ext;
  logic [2*HW-1:0]   f_ext;
  logic [HW-1:0]     a_half;
  logic [HW-1:0]     b_half;
  logic [2*VW-1:0]   pp_shift;
  logic [KW:0]       cur;
  logic              qbit;
  logic [2*VW-1:0]   quot;

  assign c_ext  = (2*HW)'(c_r);
  assign f_ext  = (2*HW)'(f_r);
  assign a_half = ph_r[1] ? c_ext[2*HW-1:HW] : c_ext[HW-1:0];
  assign b_half = ph_r[0] ? f_ext[2*HW-1:HW] : f_ext[HW-1:0];

  always_comb begin
    case (sh_r)
      2'd0:    pp_shift = (2*VW)'(pp_r);
      2'd1:    pp_shift = (2*VW)'(pp_r) << HW;
      default: pp_shift = (2*VW)'(pp_r) << (2 * HW);
    endcase
  end

  assign cur  = {rem_r, acc_r[2*VW-1]};
  assign qbit = (cur >= {1'b0, j_r});
  assign quot = {acc_r[2*VW-2:0], qbit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        B_IDLE: begin
          if (req.start) begin
            k_r <= req.k;
            if (req.n < VW'(req.k)) begin
              val_r  <= '0;
              sat_r  <= 1'b0;
              done_r <= 1'b1;
            end else begin
              c_r   <= VW'(1);
              j_r   <= KW'(1);
              f_r   <= req.n - VW'(req.k) + VW'(1);
              acc_r <= '0;
              ph_r  <= '0;
              st_r  <= B_MUL;
            end
          end
        end
        B_MUL: begin
          // partial products in phases 0..3, each registered and then added into the accumulator
          if (ph_r != 3'd4) begin
            pp_r <= a_half * b_half;
            sh_r <= 2'(ph_r[1]) + 2'(ph_r[0]);
          end
          if (ph_r != 3'd0) begin
            acc_r <= acc_r + pp_shift;
          end
          if (ph_r == 3'd4) begin
            rem_r <= '0;
            cnt_r <= '0;
            st_r  <= B_DIV;
          end else begin
            ph_r <= ph_r + 3'd1;
          end
        end
        B_DIV: begin
          rem_r <= qbit ? KW'(cur - {1'b0, j_r}) : cur[KW-1:0];
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r != CW'(2*VW-1)) begin
            acc_r <= quot;
          end else begin
            if (|quot[2*VW-1:VW]) begin
              val_r  <= cru_pkg::VMAX;
              sat_r  <= 1'b1;
              done_r <= 1'b1;
              st_r   <= B_IDLE;
            end else if (j_r == k_r) begin
              val_r  <= quot[VW-1:0];
              sat_r  <= 1'b0;
              done_r <= 1'b1;
              st_r   <= B_IDLE;
            end else begin
              c_r   <= quot[VW-1:0];
              j_r   <= j_r + KW'(1);
              f_r   <= f_r + VW'(1);
              acc_r <= '0;
              ph_r  <= '0;
              st_r  <= B_MUL;
            end
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assign rsp.busy = (st_r != B_IDLE);
  assign rsp.done = done_r;
  assign rsp.sat  = sat_r;
  assign rsp.val  = val_r;

endmodule

// ===== hw/rtl/combinadic_rank_unrank.sv =====
// Combinatorial number system rank / unrank of m-element subsets, m set by register.
// A kind 0 request carries one element; the m-th element yields the saturating rank
// sum of C(v_i, i). A kind 1 request carries a rank and yields m elements from
// position m down to 1, plain or in gap form. Every binomial runs on one shared unit
// that works factor by factor, with a 32x32 multiplier over four phases and a
// divider giving one quotient bit a cycle, so C(v, i) runs through up to i factors.
// Ranking element i runs C(v, i), after S_RGAP and S_RVAL in gap form and before
// S_REMIT when the rank goes out; unranking runs a binary search of up to 64 probes
// of C(mid, i) each for position i, then S_URD, S_URD2 and S_UEMIT per element.
// One request is worked on at a time; the request channel is ready only while the
// sequencer is idle.
// depends on cru_pkg, cru_if, cru_ram, cru_binom and the assertion macro header
`include "combinadic_rank_unrank_macros.svh"

module combinadic_rank_unrank (
  input  logic                        clk,
  input  logic                        rst_n,
  cru_in_if.sink                      in_req,
  cru_out_if.source                   out_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cru_pkg::CFG_AW-1:0]  paddr,
  input  logic [cru_pkg::CFG_DW-1:0]  pwdata,
  output logic [cru_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int VW = cru_pkg::VW;
  localparam int KW = cru_pkg::KW;
  localparam int AW = cru_pkg::AW;

  // sequencer states
  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_RGAP   = 15'b000000000000010,
    S_RVAL   = 15'b000000000000100,
    S_RBIN   = 15'b000000000001000,
    S_RWAIT  = 15'b000000000010000,
    S_REMIT  = 15'b000000000100000,
    S_UINIT  = 15'b000000001000000,
    S_UCMP   = 15'b000000010000000,
    S_UMID   = 15'b000000100000000,
    S_UBIN   = 15'b000001000000000,
    S_UWAIT  = 15'b000010000000000,
    S_USTORE = 15'b000100000000000,
    S_URD    = 15'b001000000000000,
    S_URD2   = 15'b010000000000000,
    S_UEMIT  = 15'b100000000000000
  } state_t;

  state_t            state_r;

  // configuration
  logic [KW-1:0]     size_r;
  logic              form_r;
  logic [KW-1:0]     m_eff;

  // ranking state
  logic [KW-1:0]     count_r;
  logic [VW-1:0]     rank_r;
  logic [VW-1:0]     gap_r;
  logic              ovf_r;
  logic [VW-1:0]     val_r;
  logic [VW-1:0]     v_r;
  logic [KW-1:0]     pos;

  // unranking state
  logic [VW-1:0]     alpha_r;
  logic [VW-1:0]     lo_r;
  logic [VW-1:0]     hi_r;
  logic [VW-1:0]     d_r;
  logic [VW-1:0]     mid_r;
  logic [VW-1:0]     clo_r;
  logic [KW-1:0]     i_r;
  logic [VW-1:0]     cur_r;

  // result register
  logic              ov_r;
  logic              okind_r;
  logic [VW-1:0]     oval_r;
  logic [KW-1:0]     opos_r;
  logic              oovf_r;
  logic              olast_r;
  logic              out_free;
  logic              res_load;

  // shared binomial unit
  cru_pkg::bin_req_t bin_req;
  cru_pkg::bin_rsp_t bin_rsp;
  logic              bin_wait;

  // element store
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [VW-1:0]     ram_rdata;

  // saturating adders
  logic [VW:0]       gap_sum;
  logic [VW:0]       v_sum;
  logic [VW:0]       rank_sum;
  logic              fits;
  logic [VW-1:0]     elem_out;
  logic              cfg_wr;

  // size 0 acts as 1, anything above the limit as the limit
  always_comb begin
    if (size_r == '0) begin
      m_eff = KW'(1);
    end else if (size_r > KW'(cru_pkg::MAX_SUBSET)) begin
      m_eff = KW'(cru_pkg::MAX_SUBSET);
    end else begin
      m_eff = size_r;
    end
  end

  assign pos      = count_r + KW'(1);
  assign gap_sum  = {1'b0, gap_r} + {1'b0, val_r};
  assign v_sum    = {1'b0, gap_r} + (VW+1)'(count_r);
  assign rank_sum = {1'b0, rank_r} + {1'b0, bin_rsp.val};
  assign fits     = !bin_rsp.sat && (bin_rsp.val <= alpha_r);
  assign out_free = !ov_r || out_res.ready;
  assign res_load = ((state_r == S_REMIT) || (state_r == S_UEMIT)) && out_free;

  // gap form emits the difference minus one, except at position one
  assign elem_out = (form_r && (i_r > KW'(1))) ? (cur_r - ram_rdata - VW'(1)) : cur_r;

  assign bin_req.start = (state_r == S_RBIN) || (state_r == S_UBIN);
  assign bin_req.n     = (state_r == S_RBIN) ? v_r : mid_r;
  assign bin_req.k     = (state_r == S_RBIN) ? pos : i_r;
  assign bin_wait      = (state_r == S_RWAIT) || (state_r == S_UWAIT);

  cru_binom u_binom (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (bin_req),
    .rsp   (bin_rsp)
  );

  // elem[i] lives at address i - 1
  assign ram_we = (state_r == S_USTORE);
  assign ram_re = (state_r == S_URD) || ((state_r == S_URD2) && (i_r > KW'(1)));
  assign ram_raddr = (state_r == S_URD) ? AW'(i_r - KW'(1)) : AW'(i_r - KW'(2));

  cru_ram #(
    .WIDTH (VW),
    .DEPTH (cru_pkg::MAX_SUBSET)
  ) u_elem_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(i_r - KW'(1))),
    .wdata (lo_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration port, writes complete in the access phase
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      cru_pkg::REG_SUBSET_SIZE:  prdata = cru_pkg::CFG_DW'(size_r);
      cru_pkg::REG_ELEMENT_FORM: prdata = cru_pkg::CFG_DW'(form_r);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= KW'(1);
      form_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        cru_pkg::REG_SUBSET_SIZE:  size_r <= pwdata[KW-1:0];
        cru_pkg::REG_ELEMENT_FORM: form_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign in_req.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      rank_r  <= '0;
      gap_r   <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      // a new result replaces the one taken at this edge
      if (res_load) begin
        ov_r <= 1'b1;
      end else if (out_res.ready) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            val_r   <= in_req.value[VW-1:0];
            v_r     <= in_req.value[VW-1:0];
            alpha_r <= in_req.value[VW-1:0];
            i_r     <= m_eff;
            if (in_req.kind) begin
              state_r <= S_UINIT;
            end else if (form_r) begin
              state_r <= S_RGAP;
            end else begin
              state_r <= S_RBIN;
            end
          end
        end
        // gap form: running prefix sum, then element = prefix + (pos - 1)
        S_RGAP: begin
          gap_r   <= gap_sum[VW] ? cru_pkg::VMAX : gap_sum[VW-1:0];
          ovf_r   <= ovf_r | gap_sum[VW];
          state_r <= S_RVAL;
        end
        S_RVAL: begin
          v_r     <= v_sum[VW] ? cru_pkg::VMAX : v_sum[VW-1:0];
          ovf_r   <= ovf_r | v_sum[VW];
          state_r <= S_RBIN;
        end
        S_RBIN: state_r <= S_RWAIT;
        S_RWAIT: begin
          if (bin_rsp.done) begin
            rank_r <= rank_sum[VW] ? cru_pkg::VMAX : rank_sum[VW-1:0];
            ovf_r  <= ovf_r | bin_rsp.sat | rank_sum[VW];
            if (pos < m_eff) begin
              count_r <= pos;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_REMIT;
            end
          end
        end
        S_REMIT: begin
          if (out_free) begin
            okind_r <= 1'b0;
            oval_r  <= rank_r;
            opos_r  <= '0;
            oovf_r  <= ovf_r;
            olast_r <= 1'b1;
            count_r <= '0;
            rank_r  <= '0;
            gap_r   <= '0;
            ovf_r   <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        // binary search for the largest v with C(v, i) <= alpha
        S_UINIT: begin
          lo_r    <= VW'(i_r - KW'(1));
          hi_r    <= cru_pkg::VMAX;
          clo_r   <= '0;
          state_r <= S_UCMP;
        end
        S_UCMP: begin
          if (lo_r < hi_r) begin
            d_r     <= hi_r - lo_r;
            state_r <= S_UMID;
          end else begin
            state_r <= S_USTORE;
          end
        end
        S_UMID: begin
          mid_r   <= lo_r + (d_r >> 1) + VW'(1);
          state_r <= S_UBIN;
        end
        S_UBIN: state_r <= S_UWAIT;
        S_UWAIT: begin
          if (bin_rsp.done) begin
            if (fits) begin
              lo_r  <= mid_r;
              clo_r <= bin_rsp.val;
            end else begin
              hi_r <= mid_r - VW'(1);
            end
            state_r <= S_UCMP;
          end
        end
        S_USTORE: begin
          alpha_r <= alpha_r - clo_r;
          if (i_r == KW'(1)) begin
            i_r     <= m_eff;
            state_r <= S_URD;
          end else begin
            i_r     <= i_r - KW'(1);
            state_r <= S_UINIT;
          end
        end
        // read back elem[i] and elem[i-1], emit from position m down
        S_URD: state_r <= S_URD2;
        S_URD2: begin
          cur_r   <= ram_rdata;
          state_r <= S_UEMIT;
        end
        S_UEMIT: begin
          if (out_free) begin
            okind_r <= 1'b1;
            oval_r  <= elem_out;
            opos_r  <= i_r;
            oovf_r  <= 1'b0;
            olast_r <= (i_r == KW'(1));
            if (i_r == KW'(1)) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r - KW'(1);
              state_r <= S_URD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_res.valid        = ov_r;
  assign out_res.result_kind  = okind_r;
  assign out_res.result_value = cru_pkg::DATA_W'(oval_r);
  assign out_res.position     = opos_r;
  assign out_res.overflow     = oovf_r;
  assign out_res.last         = olast_r;

  `CRU_ASSERT_IMP(a_bin_start_idle, bin_req.start, !bin_rsp.busy, "binomial unit busy")
  `CRU_ASSERT_IMP(a_bin_done_waited, bin_rsp.done, bin_wait, "binomial result unclaimed")
  `CRU_ASSERT_IMP(a_search_order, state_r == S_UCMP, lo_r <= hi_r, "search bounds crossed")
  `CRU_ASSERT_ALWAYS(a_count_range, count_r < KW'(cru_pkg::MAX_SUBSET), "count out of range")

endmodule
